### hw/rtl/hcs_pkg.sv
// ---------------------------------------------------------------------------
// HSL colour shift package
// Shared pixel type, hue constants, lane numbering and register indexes.
// ---------------------------------------------------------------------------
package hcs_pkg;

  // Hue is kept in 1/16 degree; a full turn is 5760
  localparam int HUE_TURN  = 5760;
  localparam int HUE_SIXTH = 960;
  localparam int HW        = 13;   // hue width, 0..6719 fits
  localparam int HNUM_W    = 21;   // hue dividend width, below 6720*255
  localparam int DW        = 9;    // divisor width, divisors stay below 256

  // Divider lanes
  localparam int LANES      = 2;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT = 2'd2;
  localparam int CFG_W = 14;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

endpackage

### hw/rtl/hcs_div.sv
// ---------------------------------------------------------------------------
// HSL colour shift pipelined divider
// Restoring division, one quotient bit per stage, several lanes in step.
// ---------------------------------------------------------------------------
module hcs_div #(
  parameter int NW = 21,
  parameter int QW = 13,
  parameter int PW = 32
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  logic [hcs_pkg::LANES-1:0][NW-1:0]               in_num,
  input  logic [hcs_pkg::LANES-1:0][hcs_pkg::DW-1:0]      in_den,
  input  logic [PW-1:0]                                   in_side,
  output logic                                            out_valid,
  output logic [hcs_pkg::LANES-1:0][QW-1:0]               out_quot,
  output logic [PW-1:0]                                   out_side
);

  localparam int L = hcs_pkg::LANES;
  localparam int D = hcs_pkg::DW;

  logic [L-1:0][D-1:0]  rem_r  [QW];
  logic [L-1:0][QW-1:0] work_r [QW];
  logic [L-1:0][D-1:0]  den_r  [QW];
  logic [PW-1:0]        side_r [QW];
  logic [QW-1:0]        vld_r;

  for (genvar st = 0; st < QW; st++) begin : g_st
    logic [L-1:0][D-1:0]  rem_p;
    logic [L-1:0][QW-1:0] work_p;
    logic [L-1:0][D-1:0]  den_p;
    logic [PW-1:0]        side_p;
    logic                 vld_p;
    logic [L-1:0][D-1:0]  rem_nxt;
    logic [L-1:0][QW-1:0] work_nxt;

    // pick up the previous stage, or the raw dividend at the head
    if (st == 0) begin : g_head
      always_comb begin
        for (int ln = 0; ln < L; ln++) begin
          rem_p[ln]  = D'(in_num[ln] >> QW);
          work_p[ln] = in_num[ln][QW-1:0];
        end
      end
      assign den_p  = in_den;
      assign side_p = in_side;
      assign vld_p  = in_valid;
    end else begin : g_body
      assign rem_p  = rem_r[st-1];
      assign work_p = work_r[st-1];
      assign den_p  = den_r[st-1];
      assign side_p = side_r[st-1];
      assign vld_p  = vld_r[st-1];
    end

    // one trial subtract per lane
    always_comb begin
      logic [D:0] trial;
      logic       ge;
      for (int ln = 0; ln < L; ln++) begin
        trial = {rem_p[ln], work_p[ln][QW-1]};
        ge    = (trial >= {1'b0, den_p[ln]});
        rem_nxt[ln]  = ge ? D'(trial - {1'b0, den_p[ln]}) : D'(trial);
        work_nxt[ln] = {work_p[ln][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else if (en) begin
        vld_r[st] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st]  <= rem_nxt;
        work_r[st] <= work_nxt;
        den_r[st]  <= den_p;
        side_r[st] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = work_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

### hw/rtl/hcs_mix.sv
// ---------------------------------------------------------------------------
// HSL colour shift adjust stages
// Apply the offsets, then form the q and p levels of the HSL to RGB step.
// ---------------------------------------------------------------------------
module hcs_mix #(
  parameter int F  = 12,
  parameter int QW = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [QW-1:0]             in_hue,
  input  logic [QW-1:0]             in_sat,
  input  logic [QW-1:0]             in_light,
  input  hcs_pkg::pix_t             in_side,
  input  logic signed [13:0]        hue_off,
  input  logic signed [9:0]         sat_off,
  input  logic signed [9:0]         light_off,
  output logic                      out_valid,
  output logic [F:0]                out_q,
  output logic [F:0]                out_p,
  output logic [hcs_pkg::HW-1:0]    out_hue,
  output hcs_pkg::pix_t             out_side
);

  localparam int HW = hcs_pkg::HW;
  localparam logic [F:0] ONE  = (F+1)'(1) << F;
  localparam logic [F:0] HALF = (F+1)'(1) << (F-1);

  logic [2:0] vld_r;

  logic [HW-1:0]   h1_r, h2_r, h3_r;
  logic [F:0]      s1_r, l1_r, s2_r, l2_r, q3_r, p3_r;
  logic [2*F+1:0]  ls2_r;
  hcs_pkg::pix_t   side1_r, side2_r, side3_r;

  logic [HW-1:0]   h1_nxt;
  logic [F:0]      s1_nxt, l1_nxt, q3_nxt, p3_nxt;

  // stage 1: hue rotate and wrap, clamp saturation and lightness
  always_comb begin
    logic signed [13:0]  ho;
    logic signed [14:0]  hs;
    logic signed [F+2:0] ss, ll;
    ho = hue_off;
    if (ho > 14'sd5760)  ho = 14'sd5760;
    if (ho < -14'sd5760) ho = -14'sd5760;
    hs = $signed({2'b00, in_hue[HW-1:0]}) + 15'(ho);
    if (hs < 15'sd0) begin
      hs = hs + 15'sd5760;
    end else if (hs >= 15'sd5760) begin
      hs = hs - 15'sd5760;
    end
    h1_nxt = hs[HW-1:0];

    ss = $signed({2'b00, in_sat[F:0]})   + ((F+3)'(sat_off)   <<< (F-8));
    ll = $signed({2'b00, in_light[F:0]}) + ((F+3)'(light_off) <<< (F-8));
    if (ss < 0)                              s1_nxt = '0;
    else if (ss > $signed({2'b00, ONE}))     s1_nxt = ONE;
    else                                     s1_nxt = ss[F:0];
    if (ll < 0)                              l1_nxt = '0;
    else if (ll > $signed({2'b00, ONE}))     l1_nxt = ONE;
    else                                     l1_nxt = ll[F:0];
  end

  // stage 3: q and p from the registered product
  always_comb begin
    logic [F+1:0]        t1;
    logic [F+2:0]        qv;
    logic signed [F+3:0] pv;
    t1 = ls2_r[2*F+1:F];
    if (l2_r < HALF) begin
      qv = (F+3)'(l2_r) + (F+3)'(t1);
    end else begin
      qv = (F+3)'(l2_r) + (F+3)'(s2_r) - (F+3)'(t1);
    end
    q3_nxt = qv[F:0];
    pv = $signed({2'b00, l2_r, 1'b0}) - $signed({3'b000, qv[F:0]});
    p3_nxt = (pv < 0) ? '0 : pv[F:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      h1_r    <= h1_nxt;
      s1_r    <= s1_nxt;
      l1_r    <= l1_nxt;
      side1_r <= in_side;
      ls2_r   <= l1_r * s1_r;
      h2_r    <= h1_r;
      s2_r    <= s1_r;
      l2_r    <= l1_r;
      side2_r <= side1_r;
      q3_r    <= q3_nxt;
      p3_r    <= p3_nxt;
      h3_r    <= h2_r;
      side3_r <= side2_r;
    end
  end

  assign out_valid = vld_r[2];
  assign out_q     = q3_r;
  assign out_p     = p3_r;
  assign out_hue   = h3_r;
  assign out_side  = side3_r;

endmodule

### hw/rtl/hcs_chan.sv
// ---------------------------------------------------------------------------
// HSL colour shift channel stages
// Interpolate each colour channel from p and q by hue, scale to a byte.
// ---------------------------------------------------------------------------
module hcs_chan #(
  parameter int F = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [F:0]              in_q,
  input  logic [F:0]              in_p,
  input  logic [hcs_pkg::HW-1:0]  in_hue,
  input  hcs_pkg::pix_t           in_side,
  output logic                    out_valid,
  output hcs_pkg::pix_t           out_pix
);

  localparam int HW = hcs_pkg::HW;
  localparam int XW = F + 11;
  localparam int YW = F + 5;
  localparam logic [YW-1:0] RCP = YW'((1 << YW) / 15);
  localparam logic [F:0]    ONE = (F+1)'(1) << F;

  typedef enum logic [1:0] {SEG_RISE, SEG_FLAT, SEG_FALL, SEG_LOW} seg_t;

  logic [2:0] vld_r;

  logic [XW-1:0] x1_r   [3];
  seg_t          seg1_r [3];
  seg_t          seg2_r [3];
  logic [YW-1:0] y2_r   [3];
  logic [F:0]    qe2_r  [3];
  logic [F:0]    q1_r, p1_r, q2_r, p2_r;
  hcs_pkg::pix_t side1_r, side2_r, out_pix_r;

  logic [XW-1:0] x1_nxt   [3];
  seg_t          seg1_nxt [3];
  logic [F:0]    qe2_nxt  [3];
  logic [7:0]    byte_nxt [3];

  // stage 1: hue position per channel and the interpolation product
  always_comb begin
    logic signed [14:0] t;
    logic [HW-1:0]      tu;
    logic [9:0]         f;
    for (int ln = 0; ln < 3; ln++) begin
      t = $signed({2'b00, in_hue});
      if (ln == 0)      t = t + 15'sd1920;
      else if (ln == 2) t = t - 15'sd1920;
      if (t < 15'sd0) begin
        t = t + 15'sd5760;
      end else if (t > 15'sd5760) begin
        t = t - 15'sd5760;
      end
      tu = t[HW-1:0];
      if (tu < 13'd960) begin
        seg1_nxt[ln] = SEG_RISE;
        f = tu[9:0];
      end else if (tu < 13'd2880) begin
        seg1_nxt[ln] = SEG_FLAT;
        f = '0;
      end else if (tu < 13'd3840) begin
        seg1_nxt[ln] = SEG_FALL;
        f = 10'(13'd3840 - tu);
      end else begin
        seg1_nxt[ln] = SEG_LOW;
        f = '0;
      end
      x1_nxt[ln] = XW'(in_q - in_p) * XW'(f);
    end
  end

  // stage 2: divide by 960 as a shift by 64 and a reciprocal of 15
  always_comb begin
    logic [YW-1:0]   y;
    logic [2*YW-1:0] prod;
    for (int ln = 0; ln < 3; ln++) begin
      y    = x1_r[ln][XW-1:6];
      prod = (2*YW)'(y) * (2*YW)'(RCP);
      qe2_nxt[ln] = prod[YW+F:YW];
    end
  end

  // stage 3: correct the quotient, pick the level, scale to a byte
  always_comb begin
    logic [YW-1:0] e15, rr;
    logic [F:0]    qc;
    logic [F+1:0]  c;
    logic [F+9:0]  w;
    for (int ln = 0; ln < 3; ln++) begin
      e15 = YW'({qe2_r[ln], 4'b0000}) - YW'(qe2_r[ln]);
      rr  = y2_r[ln] - e15;
      qc  = (rr >= YW'(15)) ? qe2_r[ln] + (F+1)'(1) : qe2_r[ln];
      case (seg2_r[ln])
        SEG_RISE, SEG_FALL: c = (F+2)'(p2_r) + (F+2)'(qc);
        SEG_FLAT:           c = (F+2)'(q2_r);
        default:            c = (F+2)'(p2_r);
      endcase
      if (c > (F+2)'(ONE)) c = (F+2)'(ONE);
      w = ((F+10)'(c) << 8) - (F+10)'(c);
      byte_nxt[ln] = w[F+7:F];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // advance the payload; transparent items keep their colour
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt;
      seg1_r  <= seg1_nxt;
      q1_r    <= in_q;
      p1_r    <= in_p;
      side1_r <= in_side;
      for (int ln = 0; ln < 3; ln++) begin
        y2_r[ln] <= x1_r[ln][XW-1:6];
      end
      qe2_r   <= qe2_nxt;
      seg2_r  <= seg1_r;
      q2_r    <= q1_r;
      p2_r    <= p1_r;
      side2_r <= side1_r;
      out_pix_r.alpha <= side2_r.alpha;
      if (side2_r.alpha == 8'd0) begin
        out_pix_r.red   <= side2_r.red;
        out_pix_r.green <= side2_r.green;
        out_pix_r.blue  <= side2_r.blue;
      end else begin
        out_pix_r.red   <= byte_nxt[0];
        out_pix_r.green <= byte_nxt[1];
        out_pix_r.blue  <= byte_nxt[2];
      end
    end
  end

  assign out_valid = vld_r[2];
  assign out_pix   = out_pix_r;

endmodule

### hw/rtl/hsl_color_shift_pixel_top.sv
// Pipeline: front stage, one-bit-per-stage divider, adjust stages, channel stages;
//   QW = max(13, FRACTION_BITS + 1) is the divider quotient width.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous, active low; clears the valid bits and the three offsets to zero.
// ---------------------------------------------------------------------------
// HSL colour shift pixel top
// RGB to HSL, offset hue, saturation and lightness, and back to RGB.
// ---------------------------------------------------------------------------
module hsl_color_shift_pixel_top #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_alpha,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  input  logic                            cfg_we,
  input  logic [hcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcs_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int F  = FRACTION_BITS;
  localparam int QW = (F + 1 > hcs_pkg::HW) ? F + 1 : hcs_pkg::HW;
  localparam int NW = (F + 9 > hcs_pkg::HNUM_W) ? F + 9 : hcs_pkg::HNUM_W;
  localparam int L  = hcs_pkg::LANES;
  localparam int D  = hcs_pkg::DW;
  localparam int PIX_W = $bits(hcs_pkg::pix_t);
  localparam int PW    = PIX_W + F + 1;
  localparam int HW_BASE = hcs_pkg::HW;
  localparam int LRW     = F + 9;
  localparam logic [LRW-1:0] LIGHT_RCP = LRW'(((longint'(1) << (F + 16)) + 254) / 255);

  logic adv;

  logic signed [13:0] hue_off_r;
  logic signed [9:0]  sat_off_r;
  logic signed [9:0]  light_off_r;

  logic                   fvld_r;
  logic [L-1:0][NW-1:0]   fnum_r, fnum_nxt;
  logic [L-1:0][D-1:0]    fden_r, fden_nxt;
  logic [F:0]             flight_nxt;
  logic [PW-1:0]          fside_r;

  logic                   dvld;
  logic [L-1:0][QW-1:0]   dquot;
  logic [PW-1:0]          dside;

  logic                   mvld;
  logic [F:0]             mq, mp;
  logic [hcs_pkg::HW-1:0] mhue;
  hcs_pkg::pix_t          mside;
  hcs_pkg::pix_t          opix;

  // hold the whole pipeline while a result waits
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_off_r   <= '0;
      sat_off_r   <= '0;
      light_off_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hcs_pkg::CFG_HUE:   hue_off_r   <= cfg_wdata[13:0];
        hcs_pkg::CFG_SAT:   sat_off_r   <= cfg_wdata[9:0];
        hcs_pkg::CFG_LIGHT: light_off_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // front stage: max, min, the two dividends and divisors, and the lightness
  always_comb begin
    logic [7:0]         mx, mn, d;
    logic [8:0]         sum;
    logic signed [9:0]  diff;
    logic [HW_BASE-1:0] base;
    logic [20:0]        bd;
    logic signed [22:0] hn;
    logic [F+17:0]      lp;
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    sum = 9'(mx) + 9'(mn);
    d   = mx - mn;
    if (mx == in_red) begin
      diff = $signed({2'b00, in_green}) - $signed({2'b00, in_blue});
      base = (in_green < in_blue) ? HW_BASE'(hcs_pkg::HUE_TURN) : '0;
    end else if (mx == in_green) begin
      diff = $signed({2'b00, in_blue}) - $signed({2'b00, in_red});
      base = HW_BASE'(2 * hcs_pkg::HUE_SIXTH);
    end else begin
      diff = $signed({2'b00, in_red}) - $signed({2'b00, in_green});
      base = HW_BASE'(4 * hcs_pkg::HUE_SIXTH);
    end
    bd = 21'(base) * 21'(d);
    hn = $signed({2'b00, bd}) + 23'(diff) * 23'sd960;
    fnum_nxt[hcs_pkg::LANE_HUE]   = NW'(hn[20:0]);
    fnum_nxt[hcs_pkg::LANE_SAT]   = NW'(d) << F;
    if (d == 8'd0) begin
      fden_nxt[hcs_pkg::LANE_HUE] = 9'd1;
      fden_nxt[hcs_pkg::LANE_SAT] = 9'd1;
    end else begin
      fden_nxt[hcs_pkg::LANE_HUE] = 9'(d);
      fden_nxt[hcs_pkg::LANE_SAT] = (sum <= 9'd255) ? sum : 9'd510 - sum;
    end
    // lightness: divide by 510 with a rounded-up reciprocal, exact for sums up to 510
    lp         = (F+18)'(sum) * (F+18)'(LIGHT_RCP);
    flight_nxt = lp[F+17:17];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= 1'b0;
    end else if (adv) begin
      fvld_r <= in_valid;
    end
  end

  // carry the lightness beside the pixel through the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      fnum_r  <= fnum_nxt;
      fden_r  <= fden_nxt;
      fside_r <= {flight_nxt, in_red, in_green, in_blue, in_alpha};
    end
  end

  hcs_div #(.NW(NW), .QW(QW), .PW(PW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fvld_r),
    .in_num    (fnum_r),
    .in_den    (fden_r),
    .in_side   (fside_r),
    .out_valid (dvld),
    .out_quot  (dquot),
    .out_side  (dside)
  );

  hcs_mix #(.F(F), .QW(QW)) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (dvld),
    .in_hue    (dquot[hcs_pkg::LANE_HUE]),
    .in_sat    (dquot[hcs_pkg::LANE_SAT]),
    .in_light  (QW'(dside[PW-1:PIX_W])),
    .in_side   (hcs_pkg::pix_t'(dside[PIX_W-1:0])),
    .hue_off   (hue_off_r),
    .sat_off   (sat_off_r),
    .light_off (light_off_r),
    .out_valid (mvld),
    .out_q     (mq),
    .out_p     (mp),
    .out_hue   (mhue),
    .out_side  (mside)
  );

  hcs_chan #(.F(F)) u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (mvld),
    .in_q      (mq),
    .in_p      (mp),
    .in_hue    (mhue),
    .in_side   (mside),
    .out_valid (out_valid),
    .out_pix   (opix)
  );

  assign out_red   = opix.red;
  assign out_green = opix.green;
  assign out_blue  = opix.blue;
  assign out_alpha = opix.alpha;

endmodule

### hw/rtl/hcs_checker.sv
// ---------------------------------------------------------------------------
// HSL colour shift port checker
// Watches the handshake ports of the top level over time.
// ---------------------------------------------------------------------------
module hcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result changed");

  // a stall at the output reaches the input
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // with no result waiting the input is open
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input closed with empty output");

endmodule

bind hsl_color_shift_pixel_top hcs_checker u_hcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha)
);
